[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, idle during reset.
`define RSBV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset.
`define RSBV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rsbv_pkg.sv]
package rsbv_pkg;

	localparam int unsigned WORD_BITS_C       = 32;
	localparam int unsigned WORD_SH_C         = 5;
	localparam int unsigned WORDS_PER_BLOCK_C = 8;
	localparam int unsigned MAX_WORDS_C       = 1024;

	localparam logic [2:0] OP_WRITE  = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_BUILD  = 3'd2;
	localparam logic [2:0] OP_RANK   = 3'd3;
	localparam logic [2:0] OP_SELECT = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] position;
		logic        bit_value;
	} req_t;

	typedef struct packed {
		logic [15:0] answer;
		logic        range_error;
		logic [15:0] length;
		logic [15:0] ones_count;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] word;
		logic [4:0]  k;
	} nth_req_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] pos;
	} nth_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_BUILD,
		ST_RANK_DIR,
		ST_RANK_SCAN,
		ST_SEL_SEARCH,
		ST_SEL_CMP,
		ST_SEL_BASE,
		ST_SEL_SCAN,
		ST_SEL_NTH
	} state_t;

	function automatic logic [5:0] pop32(input logic [31:0] x);
		logic [31:0] v;
		v = ((x >> 1) & 32'h55555555) + (x & 32'h55555555);
		v = ((v >> 2) & 32'h33333333) + (v & 32'h33333333);
		v = ((v >> 4) & 32'h0f0f0f0f) + (v & 32'h0f0f0f0f);
		v = ((v >> 8) & 32'h00ff00ff) + (v & 32'h00ff00ff);
		v = ((v >> 16) & 32'h0000ffff) + (v & 32'h0000ffff);
		return v[5:0];
	endfunction

endpackage

[sv/rsbv_nth.sv]
// Position of the k-th set bit of a word: byte pick, then bit pick.
module rsbv_nth (
	input  logic               clk,
	input  logic               arst_n,
	input  rsbv_pkg::nth_req_t nreq,
	output rsbv_pkg::nth_rsp_t nrsp
);
	import rsbv_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic [2:0] k_s1;
	logic [1:0] bsel_s1;
	logic [1:0] bsel_c;
	logic [5:0] sub_c;
	logic [2:0] bit_c;
	logic       v_s2;
	logic [4:0] pos_s2;

	always_comb begin
		logic [5:0] base;
		logic [5:0] p;
		logic       found;
		base   = '0;
		found  = 1'b0;
		bsel_c = '0;
		sub_c  = '0;
		for (int i = 0; i < 4; i++) begin
			p = pop32({24'b0, nreq.word[8*i +: 8]});
			if (!found && ({1'b0, nreq.k} < base + p)) begin
				found  = 1'b1;
				bsel_c = 2'(i);
				sub_c  = base;
			end
			base = base + p;
		end
	end

	always_comb begin
		logic [3:0] cnt;
		logic       hit;
		cnt   = '0;
		hit   = 1'b0;
		bit_c = '0;
		for (int j = 0; j < 8; j++) begin
			if (byte_s1[j]) begin
				if (!hit && cnt == {1'b0, k_s1}) begin
					hit   = 1'b1;
					bit_c = 3'(j);
				end
				cnt = cnt + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= nreq.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		byte_s1 <= nreq.word[8*bsel_c +: 8];
		k_s1    <= 3'(6'({1'b0, nreq.k}) - sub_c);
		bsel_s1 <= bsel_c;
		pos_s2  <= {bsel_s1, bit_c};
	end

	assign nrsp = {v_s2, pos_s2};

endmodule

[sv/rank_select_bit_vector_top.sv]
// Bit vector with a rank/select directory, stored in one word memory and one
// directory memory (both with registered synchronous reads). Requests are
// taken when start is high and busy is low; each request gives one result,
// shown on rsp for exactly one cycle with done high; the receiver cannot
// stall it. Rank reads the directory, then scans words (at most
// WORDS_PER_BLOCK); select runs a directory search, then scans words and
// picks the bit, or scans words from the start when no directory is built;
// build and clear both go one word a cycle through the word memory port;
// range errors and unknown opcodes are answered from idle. After reset the
// block runs a clearing pass over all MAX_WORDS words with busy high.
module rank_select_bit_vector_top #(
	parameter int unsigned WORDS_PER_BLOCK = rsbv_pkg::WORDS_PER_BLOCK_C,
	parameter int unsigned MAX_WORDS       = rsbv_pkg::MAX_WORDS_C
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rsbv_pkg::req_t req,
	output logic           done,
	output rsbv_pkg::rsp_t rsp
);
	import rsbv_pkg::*;

	localparam int unsigned AW         = $clog2(MAX_WORDS);
	localparam int unsigned DIR_DEPTH  = (MAX_WORDS + WORDS_PER_BLOCK - 1) / WORDS_PER_BLOCK;
	localparam int unsigned DW         = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
	localparam int unsigned OW         = $clog2(WORDS_PER_BLOCK);
	localparam int unsigned BLOCK_BITS = WORD_BITS_C * WORDS_PER_BLOCK;
	localparam int unsigned CAPACITY   = MAX_WORDS * WORD_BITS_C;
	// exact for word indexes below 2^11 and block sizes up to 16
	localparam int unsigned RECIP      = (65536 + WORDS_PER_BLOCK - 1) / WORDS_PER_BLOCK;

	logic [31:0] word_mem [MAX_WORDS];
	logic [15:0] dir_mem [DIR_DEPTH];

	state_t      state_q, state_d;
	logic [15:0] pos_q;
	logic        b_q;
	logic [16:0] len_q;
	logic [15:0] total_q;
	logic [DW:0] built_q;
	logic [AW:0] idx_q;
	logic [AW-1:0] qs_q;
	logic [DW-1:0] ql_q;
	logic [4:0]  last5_q;
	logic [15:0] acc_q;
	logic [31:0] rem_q;
	logic [DW:0] lo_q, hi_q, mid_q;
	logic [OW-1:0] cb_off_q;
	logic [DW:0] cb_blk_q, bcnt_q;
	logic [AW-1:0] sel_word_q;
	logic        report_q;
	logic        rvalid_s1;
	logic [AW-1:0] ridx_s1;
	logic [31:0] word_rd_q;
	logic [15:0] dir_rd_q;
	rsp_t        rsp_q;
	logic        done_q;

	// memory controls
	logic          word_re, word_we;
	logic [AW-1:0] word_raddr, word_waddr;
	logic [31:0]   word_wdata;
	logic          dir_we;
	logic [DW-1:0] dir_raddr, dir_waddr;
	logic [15:0]   dir_wdata;

	logic        fin, fin_err;
	logic [15:0] fin_ans;

	// request decode
	logic        accept;
	logic [15:0] last_in;
	logic [31:0] qs_in, ql_prod, lim;
	logic [DW-1:0] ql_in;
	logic        wr_err, rd_err, rank_err, sel_err;

	// datapath
	logic [31:0] used_c, stream_w, rank_mask;
	logic [5:0]  stream_pop;
	logic        w_used, blk_start;
	logic [15:0] acc_next;
	logic [16:0] len_wr;
	logic [DW+1:0] lohi;
	logic [DW:0] mid_c, blk_c;
	logic [31:0] c_dir, rem_base;
	logic        sel_hit;
	nth_req_t    nreq;
	nth_rsp_t    nrsp;

	assign accept  = start && !busy;
	assign last_in = req.position - 16'd1;
	assign qs_in   = 32'(last_in >> WORD_SH_C);
	assign ql_prod = qs_in * 32'(RECIP);
	assign ql_in   = DW'(ql_prod >> 16);
	assign lim     = req.bit_value ? 32'(total_q)
		: ((32'(len_q) > 32'(total_q)) ? 32'(len_q) - 32'(total_q) : 32'd0);
	assign wr_err  = 32'(req.position) >= 32'(CAPACITY);
	assign rd_err  = {1'b0, req.position} >= len_q;
	assign rank_err = ({1'b0, req.position} > len_q)
		|| (req.position != 16'd0 && qs_in >= 32'(MAX_WORDS));
	assign sel_err = 32'(req.position) >= lim;

	assign used_c     = ((32'(len_q) + 32'd31) >> WORD_SH_C) > 32'(MAX_WORDS)
		? 32'(MAX_WORDS) : ((32'(len_q) + 32'd31) >> WORD_SH_C);
	assign stream_w   = b_q ? word_rd_q : ~word_rd_q;
	assign stream_pop = pop32(stream_w);
	assign w_used     = 32'(ridx_s1) < used_c;
	assign blk_start  = (cb_off_q == '0);
	assign acc_next   = acc_q + (w_used ? 16'(pop32(word_rd_q)) : 16'd0);
	assign len_wr     = ({1'b0, pos_q} >= len_q) ? ({1'b0, pos_q} + 17'd1) : len_q;
	assign rank_mask  = 32'hffffffff >> (5'd31 - last5_q);
	assign lohi       = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c      = lohi[DW+1:1];
	assign blk_c      = (lo_q == '0) ? '0 : lo_q - 1'b1;
	// directory count of the kind asked for, before block mid_q
	assign c_dir      = b_q ? 32'(dir_rd_q)
		: 32'(mid_q) * 32'(BLOCK_BITS) - 32'(dir_rd_q);
	assign rem_base   = rem_q - c_dir;
	assign sel_hit    = rem_q < 32'(stream_pop);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (idx_q == (AW+1)'(MAX_WORDS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (req.opcode)
						OP_WRITE:  state_d = wr_err ? ST_IDLE : ST_WR;
						OP_READ:   state_d = rd_err ? ST_IDLE : ST_RD;
						OP_BUILD:  state_d = ST_BUILD;
						OP_RANK: begin
							state_d = (rank_err || req.position == 16'd0)
								? ST_IDLE : ST_RANK_DIR;
						end
						OP_SELECT: begin
							if (sel_err)
								state_d = ST_IDLE;
							else if (built_q == '0)
								state_d = ST_SEL_SCAN;
							else
								state_d = ST_SEL_SEARCH;
						end
						OP_CLEAR:  state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR, ST_RD: state_d = ST_IDLE;
			ST_BUILD: begin
				if (rvalid_s1 && ridx_s1 == AW'(MAX_WORDS - 1))
					state_d = ST_IDLE;
			end
			ST_RANK_DIR: state_d = ST_RANK_SCAN;
			ST_RANK_SCAN: begin
				if (rvalid_s1 && ridx_s1 == qs_q)
					state_d = ST_IDLE;
			end
			ST_SEL_SEARCH: state_d = (lo_q < hi_q) ? ST_SEL_CMP : ST_SEL_BASE;
			ST_SEL_CMP:    state_d = ST_SEL_SEARCH;
			ST_SEL_BASE:   state_d = ST_SEL_SCAN;
			ST_SEL_SCAN: begin
				if (rvalid_s1 && sel_hit)
					state_d = ST_SEL_NTH;
				else if (rvalid_s1 && ridx_s1 == AW'(MAX_WORDS - 1))
					state_d = ST_IDLE;
			end
			ST_SEL_NTH: begin
				if (nrsp.valid)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		busy       = (state_q != ST_IDLE);
		word_re    = 1'b0;
		word_raddr = idx_q[AW-1:0];
		word_we    = 1'b0;
		word_waddr = AW'(pos_q >> WORD_SH_C);
		word_wdata = (word_rd_q & ~(32'd1 << pos_q[4:0])) | (32'(b_q) << pos_q[4:0]);
		dir_we     = 1'b0;
		dir_raddr  = '0;
		dir_waddr  = cb_blk_q[DW-1:0];
		dir_wdata  = w_used ? acc_q : 16'd0;
		fin        = 1'b0;
		fin_err    = 1'b0;
		fin_ans    = '0;
		nreq.valid = 1'b0;
		nreq.word  = stream_w;
		nreq.k     = rem_q[4:0];
		case (state_q)
			ST_CLEAR: begin
				word_we    = 1'b1;
				word_waddr = idx_q[AW-1:0];
				word_wdata = '0;
				dir_we     = idx_q < (AW+1)'(DIR_DEPTH);
				dir_waddr  = DW'(idx_q);
				dir_wdata  = '0;
				fin        = report_q && idx_q == (AW+1)'(MAX_WORDS - 1);
			end
			ST_IDLE: begin
				word_raddr = AW'(req.position >> WORD_SH_C);
				dir_raddr  = ql_in;
				if (start) begin
					case (req.opcode)
						OP_WRITE: begin
							fin     = wr_err;
							fin_err = wr_err;
						end
						OP_READ: begin
							fin     = rd_err;
							fin_err = rd_err;
						end
						OP_RANK: begin
							fin     = rank_err || req.position == 16'd0;
							fin_err = rank_err;
						end
						OP_SELECT: begin
							fin     = sel_err;
							fin_err = sel_err;
						end
						OP_BUILD, OP_CLEAR: fin = 1'b0;
						default: fin = 1'b1;
					endcase
				end
			end
			ST_WR: begin
				word_we = 1'b1;
				fin     = 1'b1;
			end
			ST_RD: begin
				fin     = 1'b1;
				fin_ans = 16'(word_rd_q[pos_q[4:0]]);
			end
			ST_BUILD: begin
				word_re = idx_q < (AW+1)'(MAX_WORDS);
				dir_we  = rvalid_s1 && blk_start;
				fin     = rvalid_s1 && ridx_s1 == AW'(MAX_WORDS - 1);
			end
			ST_RANK_DIR: begin
				word_re = idx_q <= {1'b0, qs_q};
			end
			ST_RANK_SCAN: begin
				word_re = idx_q <= {1'b0, qs_q};
				fin     = rvalid_s1 && ridx_s1 == qs_q;
				fin_ans = acc_q + 16'(pop32(stream_w & rank_mask));
			end
			ST_SEL_SEARCH: begin
				dir_raddr = (lo_q < hi_q) ? mid_c[DW-1:0] : blk_c[DW-1:0];
			end
			ST_SEL_SCAN: begin
				word_re    = idx_q < (AW+1)'(MAX_WORDS);
				nreq.valid = rvalid_s1 && sel_hit;
				fin        = rvalid_s1 && !sel_hit && ridx_s1 == AW'(MAX_WORDS - 1);
				fin_err    = 1'b1;
			end
			ST_SEL_NTH: begin
				fin     = nrsp.valid;
				fin_ans = 16'(32'({sel_word_q, nrsp.pos}));
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (word_we)
			word_mem[word_waddr] <= word_wdata;
		word_rd_q <= word_mem[word_raddr];
	end

	always_ff @(posedge clk) begin
		if (dir_we)
			dir_mem[dir_waddr] <= dir_wdata;
		dir_rd_q <= dir_mem[dir_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			idx_q     <= '0;
			len_q     <= '0;
			total_q   <= '0;
			built_q   <= '0;
			report_q  <= 1'b0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= word_re;
			done_q    <= fin;
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (AW+1)'(MAX_WORDS - 1))
						report_q <= 1'b0;
				end
				ST_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_BUILD: idx_q <= '0;
							OP_RANK:  idx_q <= (AW+1)'(32'(ql_in) * 32'(WORDS_PER_BLOCK));
							OP_SELECT: idx_q <= '0;
							OP_CLEAR: begin
								idx_q    <= '0;
								report_q <= 1'b1;
								len_q    <= '0;
								total_q  <= '0;
								built_q  <= '0;
							end
							default: idx_q <= idx_q;
						endcase
					end
				end
				ST_WR: len_q <= len_wr;
				ST_BUILD: begin
					if (word_re)
						idx_q <= idx_q + 1'b1;
					if (rvalid_s1 && ridx_s1 == AW'(MAX_WORDS - 1)) begin
						total_q <= acc_next;
						built_q <= bcnt_q + (DW+1)'(blk_start && w_used);
					end
				end
				ST_RANK_DIR, ST_RANK_SCAN, ST_SEL_SCAN: begin
					if (word_re)
						idx_q <= idx_q + 1'b1;
				end
				ST_SEL_BASE: idx_q <= (AW+1)'(32'(mid_q) * 32'(WORDS_PER_BLOCK));
				default: idx_q <= idx_q;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ridx_s1 <= word_raddr;
		if (fin) begin
			rsp_q.answer      <= fin_err ? 16'd0 : fin_ans;
			rsp_q.range_error <= fin_err;
			rsp_q.length      <= (state_q == ST_WR) ? len_wr[15:0] : len_q[15:0];
			rsp_q.ones_count  <= (state_q == ST_BUILD) ? acc_next : total_q;
		end
		case (state_q)
			ST_IDLE: begin
				pos_q   <= req.position;
				b_q     <= req.bit_value;
				acc_q   <= '0;
				cb_off_q <= '0;
				cb_blk_q <= '0;
				bcnt_q  <= '0;
				qs_q    <= AW'(qs_in);
				ql_q    <= ql_in;
				last5_q <= last_in[4:0];
				rem_q   <= 32'(req.position);
				lo_q    <= '0;
				hi_q    <= built_q;
			end
			ST_BUILD: begin
				if (rvalid_s1) begin
					acc_q <= acc_next;
					if (blk_start && w_used)
						bcnt_q <= bcnt_q + 1'b1;
					if (cb_off_q == OW'(WORDS_PER_BLOCK - 1)) begin
						cb_off_q <= '0;
						cb_blk_q <= cb_blk_q + 1'b1;
					end else begin
						cb_off_q <= cb_off_q + 1'b1;
					end
				end
			end
			ST_RANK_DIR: begin
				acc_q <= b_q ? dir_rd_q
					: 16'(32'(ql_q) * 32'(BLOCK_BITS)) - dir_rd_q;
			end
			ST_RANK_SCAN: begin
				if (rvalid_s1 && ridx_s1 != qs_q)
					acc_q <= acc_q + 16'(stream_pop);
			end
			ST_SEL_SEARCH: mid_q <= (lo_q < hi_q) ? mid_c : blk_c;
			ST_SEL_CMP: begin
				if ($signed(rem_q) < $signed(c_dir))
					hi_q <= mid_q;
				else
					lo_q <= mid_q + 1'b1;
			end
			ST_SEL_BASE: rem_q <= $signed(rem_base) < 0 ? 32'd0 : rem_base;
			ST_SEL_SCAN: begin
				if (rvalid_s1) begin
					if (sel_hit)
						sel_word_q <= ridx_s1;
					else
						rem_q <= rem_q - 32'(stream_pop);
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	rsbv_nth u_nth (
		.clk    (clk),
		.arst_n (arst_n),
		.nreq   (nreq),
		.nrsp   (nrsp)
	);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[sv/rsbv_checker.sv]
`include "assert_macros.svh"

module rsbv_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input rsbv_pkg::req_t req,
	input logic           done,
	input rsbv_pkg::rsp_t rsp
);
	import rsbv_pkg::*;

	// every accepted request is either in progress or answered next cycle
	`RSBV_ASSERT(a_accept_progress, clk, arst_n, (start && !busy) |=> (busy || done), "request dropped")
	// a result is shown only once the block is free again
	`RSBV_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result while busy")
	// range errors carry a zero answer
	`RSBV_ASSERT(a_err_zero, clk, arst_n, done |-> (!rsp.range_error || rsp.answer == 16'd0), "answer on error")
	// busy when reset lifts, as the clearing pass begins
	`RSBV_ASSERT_ALWAYS(a_reset_busy, clk, !arst_n |=> (busy || !arst_n), "idle after reset")

endmodule

bind rank_select_bit_vector_top rsbv_checker u_rsbv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import rsbv_pkg::*;

	localparam int unsigned CAP_BITS   = MAX_WORDS_C * WORD_BITS_C;
	localparam int unsigned BLOCK_BITS = WORD_BITS_C * WORDS_PER_BLOCK_C;
	localparam int unsigned DIR_DEPTH  = (MAX_WORDS_C + WORDS_PER_BLOCK_C - 1) / WORDS_PER_BLOCK_C;

	// Mirror of the bit vector and its rank/select directory; predicts one result per request.
	class rsbv_scoreboard;
		logic [31:0] words[MAX_WORDS_C];
		int unsigned dir[DIR_DEPTH];
		int unsigned bit_len;
		int unsigned ones_total;
		int unsigned blocks_built;
		rsp_t        pending[$];
		int          errors;
		int          n_checked;

		function void wipe();
			foreach (words[i]) words[i] = '0;
			foreach (dir[i]) dir[i] = 0;
			bit_len = 0;
			ones_total = 0;
			blocks_built = 0;
		endfunction

		function int unsigned ones_of(logic [31:0] x);
			int unsigned c;
			c = 0;
			for (int i = 0; i < 32; i++) c += 32'(x[i]);
			return c;
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			int unsigned pos, used, acc, last, qs, ql, cnt, lim, blk, lo, hi, mid;
			int          rem, c;
			logic [31:0] w;
			bit          found;
			pos = r.position;
			e = '0;
			case (r.opcode)
				OP_WRITE: begin
					if (pos >= CAP_BITS) e.range_error = 1'b1;
					else begin
						if (pos >= bit_len) bit_len = pos + 1;
						words[pos / 32][pos % 32] = r.bit_value;
					end
				end
				OP_READ: begin
					if (pos >= bit_len) e.range_error = 1'b1;
					else e.answer = 16'(words[pos / 32][pos % 32]);
				end
				OP_BUILD: begin
					used = (bit_len + 31) / 32;
					if (used > MAX_WORDS_C) used = MAX_WORDS_C;
					foreach (dir[i]) dir[i] = 0;
					acc = 0;
					for (int unsigned j = 0; j < used; j++) begin
						if (j % WORDS_PER_BLOCK_C == 0) dir[j / WORDS_PER_BLOCK_C] = acc & 16'hffff;
						acc += ones_of(words[j]);
					end
					ones_total = acc & 16'hffff;
					blocks_built = (used + WORDS_PER_BLOCK_C - 1) / WORDS_PER_BLOCK_C;
				end
				OP_RANK: begin
					if (pos > bit_len) e.range_error = 1'b1;
					else if (pos != 0) begin
						last = pos - 1;
						qs = last / 32;
						ql = last / BLOCK_BITS;
						cnt = dir[ql];
						if (!r.bit_value) cnt = ql * BLOCK_BITS - cnt;
						for (int unsigned j = ql * WORDS_PER_BLOCK_C; j < qs; j++)
							cnt += ones_of(r.bit_value ? words[j] : ~words[j]);
						w = r.bit_value ? words[qs] : ~words[qs];
						for (int unsigned k = 0; k <= last % 32; k++) cnt += 32'(w[k]);
						e.answer = cnt[15:0];
					end
				end
				OP_SELECT: begin
					lim = r.bit_value ? ones_total
						: (bit_len > ones_total ? bit_len - ones_total : 0);
					if (pos >= lim) e.range_error = 1'b1;
					else begin
						rem = pos;
						blk = 0;
						found = 1'b0;
						if (blocks_built != 0) begin
							lo = 0;
							hi = blocks_built;
							while (lo < hi) begin
								mid = (lo + hi) / 2;
								c = dir[mid];
								if (!r.bit_value) c = int'(mid * BLOCK_BITS) - c;
								if (rem < c) hi = mid;
								else lo = mid + 1;
							end
							blk = (lo == 0) ? 0 : lo - 1;
							if (r.bit_value) rem -= int'(dir[blk]);
							else rem -= int'(blk * BLOCK_BITS) - int'(dir[blk]);
							if (rem < 0) rem = 0;
						end
						for (int unsigned j = blk * WORDS_PER_BLOCK_C; j < MAX_WORDS_C && !found; j++) begin
							w = r.bit_value ? words[j] : ~words[j];
							c = ones_of(w);
							if (rem < c) begin
								for (int k = 0; k < 32; k++) begin
									if (w[k]) begin
										if (rem == 0 && !found) begin
											e.answer = 16'(j * 32 + k);
											found = 1'b1;
										end
										rem--;
									end
								end
							end else rem -= c;
						end
						if (!found) begin
							e.range_error = 1'b1;
							e.answer = '0;
						end
					end
				end
				OP_CLEAR: wipe();
				default: ;
			endcase
			e.length = bit_len[15:0];
			e.ones_count = ones_total[15:0];
			pending = {pending, e};
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (got.answer !== e.answer)
				$display("%0t: answer expected %0d actual %0d", $time, e.answer, got.answer);
			if (got.range_error !== e.range_error)
				$display("%0t: range_error expected %0d actual %0d", $time, e.range_error,
					got.range_error);
			if (got.length !== e.length)
				$display("%0t: length expected %0d actual %0d", $time, e.length, got.length);
			if (got.ones_count !== e.ones_count)
				$display("%0t: ones_count expected %0d actual %0d", $time, e.ones_count,
					got.ones_count);
			if (got !== e) errors++;
		endfunction
	endclass

	logic  clk, arst_n, start, busy, done;
	req_t  req;
	rsp_t  rsp;
	rsbv_scoreboard sb;
	bit    no_gaps;
	int    op_seen[8];

	rank_select_bit_vector_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#50_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(rsp);
	end

	// Holds start until the request is taken; an idle gap goes before it at random.
	task automatic send_request(logic [2:0] op, logic [15:0] pos, logic b);
		req_t r;
		r.opcode = op;
		r.position = pos;
		r.bit_value = b;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		op_seen[op]++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly positions up to span, now and then just past the current length or anywhere in 16 bits.
	function automatic logic [15:0] near_pos(int unsigned span);
		int unsigned p;
		case ($urandom_range(0, 9))
			0: p = $urandom_range(0, 16'hffff);
			1: p = sb.bit_len + $urandom_range(0, 2);
			default: p = $urandom_range(0, span);
		endcase
		return p[15:0];
	endfunction

	initial begin
		int unsigned span, k;
		logic [2:0] op;
		sb = new();
		sb.wipe();
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		no_gaps = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty vector, ends of the range, stale and missing directory
		send_request(OP_READ, 16'd0, 1'b0);
		send_request(OP_RANK, 16'd0, 1'b1);
		send_request(OP_SELECT, 16'd0, 1'b1);
		send_request(OP_WRITE, 16'hffff, 1'b1);
		send_request(OP_WRITE, 16'(CAP_BITS - 1), 1'b1);
		send_request(OP_WRITE, 16'd0, 1'b1);
		send_request(OP_WRITE, 16'd300, 1'b1);
		send_request(OP_SELECT, 16'd0, 1'b0);
		send_request(OP_BUILD, 16'd0, 1'b0);
		send_request(OP_RANK, 16'(CAP_BITS - 1), 1'b1);
		send_request(OP_RANK, 16'(CAP_BITS), 1'b0);
		send_request(OP_SELECT, 16'd2, 1'b1);
		send_request(OP_SELECT, 16'd3, 1'b1);
		send_request(OP_SELECT, 16'd500, 1'b0);
		send_request(OP_READ, 16'd300, 1'b0);
		send_request(OP_WRITE, 16'd300, 1'b0);
		send_request(OP_SELECT, 16'd1, 1'b1);
		send_request(OP_RANK, 16'd301, 1'b1);
		send_request(3'd6, 16'hffff, 1'b1);
		send_request(3'd7, 16'd0, 1'b0);
		send_request(OP_CLEAR, 16'd0, 1'b0);
		send_request(OP_READ, 16'd0, 1'b0);
		drain();

		// random: small vectors mostly, with a few spanning the whole store
		for (int n = 0; n < 1600; n++) begin
			if (n == 800) drain();
			if (n >= 1450) no_gaps = 1'b1;
			span = (n % 400 < 40) ? CAP_BITS - 1 : 700;
			k = $urandom_range(0, 99);
			if (k < 40) op = OP_WRITE;
			else if (k < 50) op = OP_READ;
			else if (k < 56) op = OP_BUILD;
			else if (k < 76) op = OP_RANK;
			else if (k < 96) op = OP_SELECT;
			else if (k < 98) op = OP_CLEAR;
			else op = 3'($urandom_range(6, 7));
			if (op == OP_SELECT && $urandom_range(0, 3) != 0)
				send_request(op, 16'($urandom_range(0, sb.bit_len + 2)), 1'($urandom));
			else
				send_request(op, near_pos(span), 1'($urandom));
		end
		drain();

		$display("Covered %0d results: %0d writes, %0d reads, %0d builds, %0d ranks,",
			sb.n_checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
		$display("  %0d selects, %0d clears, %0d unknown opcodes", op_seen[4], op_seen[5],
			op_seen[6] + op_seen[7]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
